// ===== sv/missing_fragment_bitmap_top_macros.svh =====
// ---------------------------------------------------------------------------
// missing fragment bitmap assertion macros
// shared concurrent check forms, clocked on clk, off while reset is active
// ---------------------------------------------------------------------------
`ifndef MISSING_FRAGMENT_BITMAP_TOP_MACROS_SVH
`define MISSING_FRAGMENT_BITMAP_TOP_MACROS_SVH

// condition holds at every edge
`define MFB_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mfb check failed");

// consequent holds in the same cycle as the antecedent
`define MFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfb check failed");

// consequent holds in the cycle after the antecedent
`define MFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfb check failed");

`endif

// ===== sv/mfb_pkg.sv =====
// ---------------------------------------------------------------------------
// mfb_pkg
// types, codes and bit helpers shared by the missing fragment bitmap
// ---------------------------------------------------------------------------
package mfb_pkg;

  localparam int IDX_W     = 10;
  localparam int BYTE_AW   = 7;
  localparam int MAX_BYTES = 128;

  typedef enum logic [1:0] {
    FUNC_REFILL   = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_FIND     = 2'd2,
    FUNC_CONTAINS = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_READ,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [BYTE_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             failed;
    logic [IDX_W-1:0] run_start;
    logic [IDX_W-1:0] run_length;
    logic             present;
    logic [IDX_W-1:0] remaining;
  } result_t;

  // position of the lowest set bit, 0 when none
  function automatic logic [2:0] first_set(input logic [7:0] d);
    logic [2:0] p;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      if (d[i]) p = 3'(i);
    end
    return p;
  endfunction

  // number of consecutive ones starting at bit 0
  function automatic logic [3:0] trail_ones(input logic [7:0] d);
    logic [3:0] c;
    logic       stop;
    c    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!d[i]) stop = 1'b1;
      else if (!stop) c = c + 4'd1;
    end
    return c;
  endfunction

endpackage

// ===== sv/mfb_if.sv =====
// ---------------------------------------------------------------------------
// mfb channel interfaces
// valid/ready channels for operation requests and results
// ---------------------------------------------------------------------------
interface mfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [9:0] index;

  modport source (output valid, func, index, input ready);
  modport sink   (input valid, func, index, output ready);
endinterface

interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic       failed;
  logic [9:0] run_start;
  logic [9:0] run_length;
  logic       present;
  logic [9:0] remaining;

  modport source (output valid, failed, run_start, run_length, present, remaining,
                  input ready);
  modport sink   (input valid, failed, run_start, run_length, present, remaining,
                  output ready);
endinterface

// ===== sv/mfb_mem.sv =====
// ---------------------------------------------------------------------------
// mfb_mem
// byte-wide bitmap store, one write and one registered read per cycle,
// swept to zero after reset
// ---------------------------------------------------------------------------
module mfb_mem #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfb_pkg::mem_req_t   req,
  output logic [7:0]          rdata,
  output logic                busy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem_r [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] ptr_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      ptr_r <= ptr_r + AW'(1);
      if (ptr_r == AW'(DEPTH - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem_r[ptr_r] <= '0;
    end else if (req.we) begin
      mem_r[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr[AW-1:0]];
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

// ===== sv/mfb_ctrl.sv =====
// ---------------------------------------------------------------------------
// mfb_ctrl
// operation sequencer: refill sweep, read-modify-write remove, byte scan
// for the first run of set bits, and single bit test
// ---------------------------------------------------------------------------
`include "missing_fragment_bitmap_top_macros.svh"

module mfb_ctrl #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  mfb_in_if.sink              in_ch,
  input  logic [9:0]          set_size,
  input  logic                mem_busy,
  input  logic [7:0]          rdata,
  output mfb_pkg::mem_req_t   mem_req,
  output logic                res_valid,
  input  logic                res_take,
  output mfb_pkg::result_t    res
);

  localparam logic [13:0] BUF_W = 14'(BUFFER_BYTES);

  mfb_pkg::state_t  state_r, state_nxt;
  mfb_pkg::func_t   op_r, op_nxt;
  mfb_pkg::result_t res_r, res_nxt;
  logic [9:0]       idx_r, idx_nxt;
  logic [6:0]       addr_r, addr_nxt;
  logic [6:0]       proc_r, proc_nxt;
  logic [7:0]       nb_r, nb_nxt;
  logic [9:0]       active_r, active_nxt;
  logic [9:0]       remaining_r, remaining_nxt;
  logic             run_r, run_nxt;
  logic [9:0]       start_r, start_nxt;
  logic [9:0]       len_r, len_nxt;

  mfb_pkg::func_t   in_func;
  logic             accept;
  logic [6:0]       in_byte;
  logic             in_store;
  logic [7:0]       fill_bytes;
  logic [7:0]       act_bytes;
  logic             fill_fits;
  logic [9:0]       base;
  logic [9:0]       span;
  logic [7:0]       mask;
  logic [7:0]       eff;
  logic [2:0]       pos;
  logic [3:0]       c_head;
  logic [3:0]       c_run;
  logic [3:0]       head_len;
  logic             last;
  logic [9:0]       run_sum;
  logic             hit;

  assign in_func    = mfb_pkg::func_t'(in_ch.func);
  assign accept     = in_ch.valid && in_ch.ready;
  assign in_byte    = in_ch.index[9:3];
  assign in_store   = {7'd0, in_byte} < BUF_W;
  assign fill_bytes = 8'(({1'b0, set_size} + 11'd7) >> 3);
  assign act_bytes  = 8'(({1'b0, active_r} + 11'd7) >> 3);
  assign fill_fits  = {6'd0, fill_bytes} < BUF_W;

  // scan of the byte that the previous cycle read
  assign base = {proc_r, 3'b000};
  assign span = active_r - base;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[k] = span > 10'(k);
    end
  end
  assign eff      = rdata & mask;
  assign pos      = mfb_pkg::first_set(eff);
  assign c_head   = mfb_pkg::trail_ones(eff >> pos);
  assign c_run    = mfb_pkg::trail_ones(eff);
  assign head_len = {1'b0, pos} + c_head;
  assign last     = ({1'b0, proc_r} + 8'd1) == nb_r;
  assign run_sum  = len_r + 10'(c_run);
  assign hit      = rdata[idx_r[2:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfb_pkg::S_CLEAR;
      active_r    <= '0;
      remaining_r <= '0;
      run_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      remaining_r <= remaining_nxt;
      run_r       <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    res_r   <= res_nxt;
    idx_r   <= idx_nxt;
    addr_r  <= addr_nxt;
    proc_r  <= proc_nxt;
    nb_r    <= nb_nxt;
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    proc_nxt      = proc_r;
    nb_nxt        = nb_r;
    active_nxt    = active_r;
    remaining_nxt = remaining_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    mem_req       = '0;
    mem_req.raddr = idx_r[9:3];
    in_ch.ready   = (state_r == mfb_pkg::S_IDLE);
    res_valid     = (state_r == mfb_pkg::S_RESULT);

    case (state_r)
      mfb_pkg::S_CLEAR: begin
        if (!mem_busy) state_nxt = mfb_pkg::S_IDLE;
      end

      mfb_pkg::S_IDLE: begin
        mem_req.raddr = (in_func == mfb_pkg::FUNC_FIND) ? 7'd0 : in_byte;
        if (accept) begin
          op_nxt            = in_func;
          idx_nxt           = in_ch.index;
          res_nxt           = '0;
          res_nxt.remaining = remaining_r;
          case (in_func)
            mfb_pkg::FUNC_REFILL: begin
              if (fill_fits) begin
                active_nxt        = set_size;
                remaining_nxt     = set_size;
                res_nxt.remaining = set_size;
                nb_nxt            = fill_bytes;
                addr_nxt          = '0;
                state_nxt = (fill_bytes == 8'd0) ? mfb_pkg::S_RESULT : mfb_pkg::S_FILL;
              end else begin
                res_nxt.failed = 1'b1;
                state_nxt      = mfb_pkg::S_RESULT;
              end
            end
            mfb_pkg::FUNC_REMOVE: begin
              state_nxt = (in_ch.index < active_r) ? mfb_pkg::S_READ : mfb_pkg::S_RESULT;
            end
            mfb_pkg::FUNC_FIND: begin
              if (active_r != 10'd0) begin
                nb_nxt    = act_bytes;
                addr_nxt  = 7'd1;
                proc_nxt  = '0;
                run_nxt   = 1'b0;
                start_nxt = '0;
                len_nxt   = '0;
                state_nxt = mfb_pkg::S_SCAN;
              end else begin
                state_nxt = mfb_pkg::S_RESULT;
              end
            end
            mfb_pkg::FUNC_CONTAINS: begin
              state_nxt = in_store ? mfb_pkg::S_READ : mfb_pkg::S_RESULT;
            end
            default: begin
              state_nxt = mfb_pkg::S_RESULT;
            end
          endcase
        end
      end

      mfb_pkg::S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_r;
        mem_req.wdata = 8'hFF;
        addr_nxt      = addr_r + 7'd1;
        if (({1'b0, addr_r} + 8'd1) == nb_r) state_nxt = mfb_pkg::S_RESULT;
      end

      mfb_pkg::S_READ: begin
        if (op_r == mfb_pkg::FUNC_REMOVE) begin
          if (hit) begin
            mem_req.we        = 1'b1;
            mem_req.waddr     = idx_r[9:3];
            mem_req.wdata     = rdata & ~(8'd1 << idx_r[2:0]);
            remaining_nxt     = remaining_r - 10'd1;
            res_nxt.remaining = remaining_r - 10'd1;
          end
        end else begin
          res_nxt.present = hit;
        end
        state_nxt = mfb_pkg::S_RESULT;
      end

      mfb_pkg::S_SCAN: begin
        // reads run one byte ahead of the byte being examined
        mem_req.raddr = addr_r;
        addr_nxt      = addr_r + 7'd1;
        proc_nxt      = proc_r + 7'd1;
        if (!run_r) begin
          if (eff != 8'd0) begin
            if (head_len == 4'd8 && !last) begin
              run_nxt   = 1'b1;
              start_nxt = base + 10'(pos);
              len_nxt   = 10'(4'd8 - {1'b0, pos});
            end else begin
              res_nxt.run_start  = base + 10'(pos);
              res_nxt.run_length = 10'(c_head);
              state_nxt          = mfb_pkg::S_RESULT;
            end
          end else if (last) begin
            state_nxt = mfb_pkg::S_RESULT;
          end
        end else begin
          if (c_run == 4'd8 && !last) begin
            len_nxt = run_sum;
          end else begin
            res_nxt.run_start  = start_r;
            res_nxt.run_length = run_sum;
            state_nxt          = mfb_pkg::S_RESULT;
          end
        end
      end

      mfb_pkg::S_RESULT: begin
        if (res_take) state_nxt = mfb_pkg::S_IDLE;
      end

      default: begin
        state_nxt = mfb_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  // remaining counts set bits below the active size, so never exceeds it
  `MFB_ASSERT(a_remaining_bound, clk, rst_n, remaining_r <= active_r)
  // the scan never looks past the last active byte
  `MFB_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == mfb_pkg::S_SCAN, ({1'b0, proc_r} < nb_r))
  // an out of range remove touches no memory and answers at once
  `MFB_ASSERT_NEXT(a_remove_skip, clk, rst_n, (accept && in_func == mfb_pkg::FUNC_REMOVE && in_ch.index >= active_r), (state_r == mfb_pkg::S_RESULT && !mem_req.we))

endmodule

// ===== sv/missing_fragment_bitmap_top.sv =====
// ---------------------------------------------------------------------------
// missing_fragment_bitmap_top
// Bitmap of outstanding fragment indices with refill, remove, find-first-run
// and contains operations.
// in_ch carries one operation per transaction (func, index); out_ch returns
// exactly one result transaction per operation, in order. cfg_we/cfg_wdata
// load the size used by the next refill.
// After acceptance, remove and contains read their byte before the result
// is registered, but go straight to the result when the index lies outside
// the active size (remove) or the store (contains); a failing or empty refill
// goes straight to the result, a refill first writes ceil(size/8) bytes, and
// find scans up to ceil(active_size/8) bytes, or none with nothing active;
// one byte of the store is read or written per cycle. The next operation is
// accepted in the cycle after the result moves out. A stalled receiver holds
// the result in the output register and the next operation waits finished in
// the sequencer until the register frees. After reset the store is swept to
// zero, one byte a cycle, over min(BUFFER_BYTES, 128) bytes; no operation is
// accepted meanwhile, while configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module missing_fragment_bitmap_top #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  mfb_in_if.sink     in_ch,
  mfb_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  localparam int MEM_DEPTH =
    (BUFFER_BYTES < mfb_pkg::MAX_BYTES) ? BUFFER_BYTES : mfb_pkg::MAX_BYTES;

  logic [9:0]        set_size_r;
  mfb_pkg::mem_req_t mem_req;
  logic [7:0]        rdata;
  logic              mem_busy;
  logic              res_valid;
  logic              res_take;
  mfb_pkg::result_t  res;
  mfb_pkg::result_t  out_res_r;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r <= '0;
    end else if (cfg_we) begin
      set_size_r <= cfg_wdata;
    end
  end

  mfb_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (rdata),
    .busy  (mem_busy)
  );

  mfb_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .set_size  (set_size_r),
    .mem_busy  (mem_busy),
    .rdata     (rdata),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register frees when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.failed     = out_res_r.failed;
  assign out_ch.run_start  = out_res_r.run_start;
  assign out_ch.run_length = out_res_r.run_length;
  assign out_ch.present    = out_res_r.present;
  assign out_ch.remaining  = out_res_r.remaining;

endmodule
